@@ rtl/nst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nst_pkg - shared types and constants of the namespace slot table
// Command and status codes, sequencer states, stream payload layouts and the
// layout of one slot memory word.
// ----------------------------------------------------------------------------
package nst_pkg;

  localparam int unsigned LIST_CAP = 16;

  localparam logic [31:0] BS_MIN = 32'd512;
  localparam logic [31:0] BS_4K  = 32'd4096;
  localparam logic [31:0] BS_16K = 32'd16384;

  typedef enum logic [2:0] {
    CMD_ATTACH  = 3'd0,
    CMD_DETACH  = 3'd1,
    CMD_INFO    = 3'd2,
    CMD_PROTECT = 3'd3,
    CMD_FORMAT  = 3'd4,
    CMD_LIST    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_NO_SLOT   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_COMMIT,
    SEQ_REPLY
  } seq_state_t;

  // Input payload, last declared field in the lowest bits.
  typedef struct packed {
    logic [1:0]  pad;
    logic [4:0]  list_limit;
    logic        protect;
    logic [31:0] block_size;
    logic [63:0] ns_size;
    logic [31:0] nsid;
  } in_data_t;

  // Result payload, last declared field in the lowest bits.
  typedef struct packed {
    logic [1:0]  pad;
    logic [4:0]  active_total;
    logic [4:0]  listed_count;
    logic        entry_protected;
    logic [31:0] entry_block_size;
    logic [63:0] entry_size;
    logic [31:0] entry_nsid;
    status_t     status;
  } out_data_t;

  typedef struct packed {
    logic      last;
    out_data_t data;
  } result_t;

  typedef struct packed {
    logic [31:0] nsid;
    logic [63:0] capacity;
    logic [31:0] block_size;
    logic        protect;
  } slot_entry_t;

  localparam int IN_DATA_W  = $bits(in_data_t);
  localparam int OUT_DATA_W = $bits(out_data_t);

endpackage

@@ rtl/nst_slot_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nst_slot_mem - slot memory
// One write port and one read port; read data is registered, so it appears in
// the cycle after the read enable.
// ----------------------------------------------------------------------------
module nst_slot_mem #(
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output nst_pkg::slot_entry_t rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  nst_pkg::slot_entry_t wr_data
);
  import nst_pkg::*;

  slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/nst_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nst_out_stage - result output register
// Holds one result until the downstream side takes it; a new result may be
// loaded in the cycle the held one leaves.
// ----------------------------------------------------------------------------
module nst_out_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  nst_pkg::result_t                push_res,
  output logic                            push_ok,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [nst_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast
);
  import nst_pkg::*;

  logic    valid;
  result_t res;

  assign push_ok  = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tdata  = res.data;
  assign m_tlast  = res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res <= push_res;
    end
  end

endmodule

@@ rtl/nst_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nst_seq - command sequencer
// Checks each command, scans the slot memory one slot per cycle (unless a listed
// entry waits) in a one-deep read pipeline, writes the changed slot and reports.
// ----------------------------------------------------------------------------
module nst_seq #(
  parameter  int NS_SLOTS = 16,
  localparam int IDX_W    = (NS_SLOTS > 1) ? $clog2(NS_SLOTS) : 1,
  localparam int CNT_W    = $clog2(NS_SLOTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_cmd,
  input  nst_pkg::in_data_t    in_data,
  output logic                 mem_rd_en,
  output logic [IDX_W-1:0]     mem_rd_addr,
  input  nst_pkg::slot_entry_t mem_rd_data,
  output logic                 mem_wr_en,
  output logic [IDX_W-1:0]     mem_wr_addr,
  output nst_pkg::slot_entry_t mem_wr_data,
  output logic                 push,
  output nst_pkg::result_t     push_res,
  input  logic                 push_ok
);
  import nst_pkg::*;

  localparam logic [4:0] LIST_CAP5 = 5'(LIST_CAP);

  seq_state_t           state, state_next;
  logic [2:0]           cmd_q, cmd_next;
  in_data_t             item_q, item_next;
  logic [NS_SLOTS-1:0]  active, active_next;
  logic [CNT_W-1:0]     active_cnt, active_cnt_next;
  logic [CNT_W-1:0]     issue_idx, issue_idx_next;
  logic [IDX_W-1:0]     eval_idx, eval_idx_next;
  logic                 eval_pend, eval_pend_next;
  logic                 found, found_next;
  logic [IDX_W-1:0]     found_idx, found_idx_next;
  slot_entry_t          match_entry, match_next;
  logic                 free_found, free_found_next;
  logic [IDX_W-1:0]     free_idx, free_idx_next;
  logic [4:0]           list_k, list_k_next;
  logic [4:0]           limit, limit_next;
  status_t              status_q, status_next;

  logic                 bad_cmd;
  logic                 hit;
  logic                 is_list;
  logic                 want_emit;
  logic                 bs_pow2;
  logic                 bs_fmt_ok;

  // Input checks that do not need the table.
  always_comb begin
    bs_pow2   = (in_data.block_size >= BS_MIN) &&
                ((in_data.block_size & (in_data.block_size - 32'd1)) == 32'd0);
    bs_fmt_ok = (in_data.block_size == 32'd0) || (in_data.block_size == BS_MIN) ||
                (in_data.block_size == BS_4K) || (in_data.block_size == BS_16K);
    unique case (in_cmd)
      CMD_ATTACH: begin
        bad_cmd = (in_data.nsid == 32'd0) || (in_data.ns_size == 64'd0) || !bs_pow2;
      end
      CMD_DETACH, CMD_INFO, CMD_PROTECT: begin
        bad_cmd = (in_data.nsid == 32'd0);
      end
      CMD_FORMAT: begin
        bad_cmd = (in_data.nsid == 32'd0) || !bs_fmt_ok;
      end
      CMD_LIST: begin
        bad_cmd = 1'b0;
      end
      default: begin
        bad_cmd = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next      = state;
    cmd_next        = cmd_q;
    item_next       = item_q;
    active_next     = active;
    active_cnt_next = active_cnt;
    issue_idx_next  = issue_idx;
    eval_idx_next   = eval_idx;
    eval_pend_next  = eval_pend;
    found_next      = found;
    found_idx_next  = found_idx;
    match_next      = match_entry;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    list_k_next     = list_k;
    limit_next      = limit;
    status_next     = status_q;

    in_ready    = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = issue_idx[IDX_W-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = found_idx;
    mem_wr_data = match_entry;
    push        = 1'b0;
    push_res    = '0;

    is_list   = (cmd_q == CMD_LIST);
    hit       = eval_pend && active[eval_idx] && (mem_rd_data.nsid == item_q.nsid);
    want_emit = is_list && eval_pend && active[eval_idx] && (list_k < limit);

    unique case (state)
      SEQ_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_next        = in_cmd;
          item_next       = in_data;
          found_next      = 1'b0;
          free_found_next = 1'b0;
          list_k_next     = '0;
          issue_idx_next  = '0;
          eval_pend_next  = 1'b0;
          limit_next      = (in_data.list_limit > LIST_CAP5) ? LIST_CAP5 :
                            in_data.list_limit;
          if (bad_cmd) begin
            status_next = ST_INVALID;
            state_next  = SEQ_REPLY;
          end else begin
            state_next = SEQ_SCAN;
          end
        end
      end

      SEQ_SCAN: begin
        if (is_list && (list_k == limit)) begin
          eval_pend_next = 1'b0;
          state_next     = SEQ_COMMIT;
        end else if (!want_emit || push_ok) begin
          // Emit a listed entry; hold the read pipeline while the output is full.
          if (want_emit) begin
            push                       = 1'b1;
            push_res.last              = 1'b0;
            push_res.data.status       = ST_OK;
            push_res.data.entry_nsid   = mem_rd_data.nsid;
            push_res.data.active_total = 5'(active_cnt);
            list_k_next                = 5'(list_k + 5'd1);
          end
          if (eval_pend && !active[eval_idx] && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = eval_idx;
          end
          if (hit && !is_list) begin
            found_next     = 1'b1;
            found_idx_next = eval_idx;
            match_next     = mem_rd_data;
            eval_pend_next = 1'b0;
            state_next     = SEQ_COMMIT;
          end else if (issue_idx == CNT_W'(NS_SLOTS)) begin
            eval_pend_next = 1'b0;
            state_next     = SEQ_COMMIT;
          end else begin
            mem_rd_en      = 1'b1;
            issue_idx_next = CNT_W'(issue_idx + 1'b1);
            eval_idx_next  = issue_idx[IDX_W-1:0];
            eval_pend_next = 1'b1;
          end
        end
      end

      SEQ_COMMIT: begin
        state_next  = SEQ_REPLY;
        status_next = ST_OK;
        unique case (cmd_q)
          CMD_ATTACH: begin
            if (found) begin
              status_next = ST_EXISTS;
            end else if (free_found) begin
              mem_wr_en              = 1'b1;
              mem_wr_addr            = free_idx;
              mem_wr_data.nsid       = item_q.nsid;
              mem_wr_data.capacity   = item_q.ns_size;
              mem_wr_data.block_size = item_q.block_size;
              mem_wr_data.protect    = 1'b0;
              active_next[free_idx]  = 1'b1;
              active_cnt_next        = CNT_W'(active_cnt + 1'b1);
            end else begin
              status_next = ST_NO_SLOT;
            end
          end
          CMD_DETACH: begin
            if (found) begin
              active_next[found_idx] = 1'b0;
              if (active_cnt != '0) begin
                active_cnt_next = CNT_W'(active_cnt - 1'b1);
              end
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
          CMD_INFO: begin
            if (!found) begin
              status_next = ST_NOT_FOUND;
            end
          end
          CMD_PROTECT: begin
            if (found) begin
              mem_wr_en           = 1'b1;
              mem_wr_data.protect = item_q.protect;
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
          CMD_FORMAT: begin
            if (found) begin
              // Zero block size keeps the current one.
              if (item_q.block_size != 32'd0) begin
                mem_wr_en              = 1'b1;
                mem_wr_data.block_size = item_q.block_size;
              end
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
          CMD_LIST: begin
            status_next = ST_OK;
          end
          default: begin
            status_next = ST_INVALID;
          end
        endcase
      end

      SEQ_REPLY: begin
        if (push_ok) begin
          push                       = 1'b1;
          push_res.last              = 1'b1;
          push_res.data.status       = status_q;
          push_res.data.active_total = 5'(active_cnt);
          if ((cmd_q == CMD_INFO) && found) begin
            push_res.data.entry_nsid       = match_entry.nsid;
            push_res.data.entry_size       = match_entry.capacity;
            push_res.data.entry_block_size = match_entry.block_size;
            push_res.data.entry_protected  = match_entry.protect;
          end
          if (is_list) begin
            push_res.data.listed_count = list_k;
          end
          state_next = SEQ_IDLE;
        end
      end

      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SEQ_IDLE;
      active     <= '0;
      active_cnt <= '0;
      eval_pend  <= 1'b0;
    end else begin
      state      <= state_next;
      active     <= active_next;
      active_cnt <= active_cnt_next;
      eval_pend  <= eval_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q       <= cmd_next;
    item_q      <= item_next;
    issue_idx   <= issue_idx_next;
    eval_idx    <= eval_idx_next;
    found       <= found_next;
    found_idx   <= found_idx_next;
    match_entry <= match_next;
    free_found  <= free_found_next;
    free_idx    <= free_idx_next;
    list_k      <= list_k_next;
    limit       <= limit_next;
    status_q    <= status_next;
  end

endmodule

@@ rtl/namespace_slot_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// namespace_slot_table_core - namespace slot table
// Attach, detach, info, protect, format and list commands over NS_SLOTS slots
// held in a synchronous slot memory.
// ----------------------------------------------------------------------------
// One command is in flight at a time. A command that fails its input checks
// goes from acceptance straight to the reply. Any other command scans the slot
// memory through its single read port, one slot per cycle, in these steps:
// acceptance, the scan, a write-back state and the reply. A search stops at the
// matching slot; a list stops at its limit and stalls its scan while the output
// register holds a result not yet taken, and the reply likewise waits for the
// output register to drain. The next command is accepted as soon as the last
// result is loaded into the output register. Slot contents need no clearing
// pass after reset: per-slot active flags gate every read.
module namespace_slot_table_core #(
  parameter int NS_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // cmd[2:0]
  input  logic [2:0]                      s_tuser,
  // nsid[31:0], ns_size[95:32], block_size[127:96], protect[128],
  // list_limit[133:129], zero[135:134]
  input  logic [nst_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[2:0], entry_nsid[34:3], entry_size[98:35], entry_block_size[130:99],
  // entry_protected[131], listed_count[136:132], active_total[141:137],
  // zero[143:142]
  output logic [nst_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast
);
  import nst_pkg::*;

  localparam int IDX_W = (NS_SLOTS > 1) ? $clog2(NS_SLOTS) : 1;

  in_data_t         in_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  slot_entry_t      mem_rd_data;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  slot_entry_t      mem_wr_data;
  logic             push;
  result_t          push_res;
  logic             push_ok;

  assign in_data = s_tdata;

  nst_seq #(
    .NS_SLOTS (NS_SLOTS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_cmd      (s_tuser),
    .in_data     (in_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .push        (push),
    .push_res    (push_res),
    .push_ok     (push_ok)
  );

  nst_slot_mem #(
    .DEPTH (NS_SLOTS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  nst_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_res (push_res),
    .push_ok  (push_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ rtl/nst_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nst_checker - port-level checks for the namespace slot table
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module nst_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [nst_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic                            m_tlast
);
  import nst_pkg::*;

  out_data_t res;

  assign res = m_tdata;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // One command at a time: no second transaction in the cycle after one.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transaction");

  a_list_entry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> res.status == ST_OK && res.listed_count == 5'd0)
    else $error("listed entry with bad status or count");

  a_list_close: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && res.listed_count != 5'd0 |->
      res.status == ST_OK && res.entry_nsid == 32'd0)
    else $error("closing list result malformed");

endmodule

bind namespace_slot_table_core nst_checker u_nst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
